>>> design/notification_flag_table_defines.svh
// Assertion macros for the notification flag table checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef NOTIFICATION_FLAG_TABLE_DEFINES_SVH
`define NOTIFICATION_FLAG_TABLE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define NFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/nft_pkg.sv
// Package for the notification flag table: sizes, op and status codes,
// request and response payload types. No dependencies.
`default_nettype none

package nft_pkg;

    localparam int NUM_OBJECTS = 16;
    localparam int MAX_THREADS = 256;
    localparam int FLAG_BITS   = 32;

    localparam int IDX_W = $clog2(NUM_OBJECTS);

    localparam logic [31:0] FLAG_MASK =
        (FLAG_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << FLAG_BITS) - 64'd1);

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_DESTROY = 3'd1,
        OP_SIGNAL  = 3'd2,
        OP_WAIT    = 3'd3,
        OP_POLL    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_BLOCKED = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  obj_index;
        logic [31:0] signal_bits;
        logic [31:0] match_mask;
        logic [7:0]  caller_thread;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  new_index;
        logic [31:0] bits_out;
        logic        wake;
        logic [7:0]  wake_thread;
    } t_rsp;

endpackage

`default_nettype wire

>>> design/nft_req_if.sv
// Request channel: valid/ready handshake with the request fields.
// Depends on nothing.
`default_nettype none

interface nft_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [3:0]  obj_index;
    logic [31:0] signal_bits;
    logic [31:0] match_mask;
    logic [7:0]  caller_thread;

    modport source (output valid, op, obj_index, signal_bits, match_mask, caller_thread,
                    input ready);
    modport sink   (input valid, op, obj_index, signal_bits, match_mask, caller_thread,
                    output ready);
endinterface

`default_nettype wire

>>> design/nft_rsp_if.sv
// Response channel: valid/ready handshake with the response fields.
// Depends on nothing.
`default_nettype none

interface nft_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  new_index;
    logic [31:0] bits_out;
    logic        wake;
    logic [7:0]  wake_thread;

    modport source (output valid, status, new_index, bits_out, wake, wake_thread,
                    input ready);
    modport sink   (input valid, status, new_index, bits_out, wake, wake_thread,
                    output ready);
    modport mon    (input valid, ready, status, new_index, bits_out, wake, wake_thread);
endinterface

`default_nettype wire

>>> design/nft_table.sv
// Object table: per-entry flags, pending bits and waiter slot, plus the
// op decode that updates one entry and forms the response. Uses nft_pkg.
`default_nettype none

module nft_table (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire nft_pkg::t_req i_req,
    output nft_pkg::t_rsp      o_rsp
);

    logic [nft_pkg::NUM_OBJECTS-1:0] r_active, n_active;
    logic [nft_pkg::NUM_OBJECTS-1:0] r_wvalid, n_wvalid;
    logic [31:0] r_pending [nft_pkg::NUM_OBJECTS];
    logic [7:0]  r_wthread [nft_pkg::NUM_OBJECTS];
    logic [31:0] r_wmask   [nft_pkg::NUM_OBJECTS];

    logic [nft_pkg::IDX_W-1:0] idx, free_idx, wr_idx;
    logic        idx_ok, have_free;
    logic [31:0] sbits, mmask;
    logic [31:0] cur_p, cur_wm, hit, sig_p, deliver;
    logic [7:0]  cur_wt;
    logic        cur_wv;
    logic        wr_en, wr_wait;
    logic [31:0] wr_p;

    assign idx    = nft_pkg::IDX_W'(i_req.obj_index);
    assign idx_ok = (32'(i_req.obj_index) < 32'(nft_pkg::NUM_OBJECTS)) && r_active[idx];
    assign sbits  = i_req.signal_bits & nft_pkg::FLAG_MASK;
    assign mmask  = i_req.match_mask & nft_pkg::FLAG_MASK;

    assign cur_p   = r_pending[idx];
    assign cur_wm  = r_wmask[idx];
    assign cur_wt  = r_wthread[idx];
    assign cur_wv  = r_wvalid[idx];
    assign hit     = cur_p & mmask;
    assign sig_p   = cur_p | sbits;
    assign deliver = sig_p & cur_wm;

    // lowest free entry
    always_comb begin
        have_free = 1'b0;
        free_idx  = '0;
        for (int i = nft_pkg::NUM_OBJECTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                have_free = 1'b1;
                free_idx  = nft_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_active = r_active;
        n_wvalid = r_wvalid;
        wr_en    = 1'b0;
        wr_wait  = 1'b0;
        wr_idx   = idx;
        wr_p     = cur_p;
        o_rsp    = '0;
        if (i_req.op == nft_pkg::OP_CREATE) begin
            if (have_free) begin
                n_active[free_idx] = 1'b1;
                n_wvalid[free_idx] = 1'b0;
                wr_en              = 1'b1;
                wr_idx             = free_idx;
                wr_p               = '0;
                o_rsp.status       = nft_pkg::ST_OK;
                o_rsp.new_index    = 4'(free_idx);
            end else begin
                o_rsp.status = nft_pkg::ST_NOSPACE;
            end
        end else if (!idx_ok || i_req.op > nft_pkg::OP_POLL) begin
            o_rsp.status = nft_pkg::ST_INVALID;
        end else begin
            unique case (i_req.op)
                nft_pkg::OP_DESTROY: begin
                    n_active[idx] = 1'b0;
                end
                nft_pkg::OP_SIGNAL: begin
                    wr_en = 1'b1;
                    wr_p  = sig_p;
                    if (cur_wv && deliver != '0) begin
                        wr_p              = sig_p & ~deliver;
                        n_wvalid[idx]     = 1'b0;
                        o_rsp.bits_out    = deliver;
                        o_rsp.wake        = 1'b1;
                        o_rsp.wake_thread = cur_wt;
                    end
                end
                nft_pkg::OP_WAIT: begin
                    if (hit != '0) begin
                        wr_en          = 1'b1;
                        wr_p           = cur_p & ~hit;
                        o_rsp.bits_out = hit;
                    end else if (32'(i_req.caller_thread) >= 32'(nft_pkg::MAX_THREADS)) begin
                        o_rsp.status = nft_pkg::ST_INVALID;
                    end else begin
                        n_wvalid[idx] = 1'b1;
                        wr_wait       = 1'b1;
                        o_rsp.status  = nft_pkg::ST_BLOCKED;
                    end
                end
                default: begin
                    wr_en          = 1'b1;
                    wr_p           = cur_p & ~hit;
                    o_rsp.bits_out = hit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_wvalid <= '0;
        end else if (i_fire) begin
            r_active <= n_active;
            r_wvalid <= n_wvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && wr_en) begin
            r_pending[wr_idx] <= wr_p;
        end
        if (i_fire && wr_wait) begin
            r_wthread[wr_idx] <= i_req.caller_thread;
            r_wmask[wr_idx]   <= mmask;
        end
    end

endmodule

`default_nettype wire

>>> design/nft_outbuf.sv
// Response register with a skid stage, so a request can be taken while a
// response waits. Uses nft_pkg.
`default_nettype none

module nft_outbuf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire nft_pkg::t_rsp i_data,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    output nft_pkg::t_rsp      o_data
);

    logic          r_ov, r_sv;
    nft_pkg::t_rsp r_out, r_skid;
    logic          pop;

    assign pop     = r_ov && i_ready;
    assign o_ready = !r_sv;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (pop) begin
                r_sv <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_ov || pop) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_ov || pop) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/notification_flag_table.sv
// Notification flag table, top level. Uses nft_pkg, nft_req_if, nft_rsp_if,
// nft_table and nft_outbuf.
//
// One request is taken per clock while i_req.ready is high and answered by
// exactly one response, in order. Table update and response are formed in the
// cycle the request is accepted; the response goes to the output register, or
// to the skid if that is full. The two-deep buffer (output register plus skid)
// keeps i_req.ready high while one response waits; ready drops only when two
// responses are pending. Create picks the lowest free entry by a priority
// encoder over the active flags. Flags clear on reset; no setup is needed.
`default_nettype none

module notification_flag_table (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    nft_req_if.sink     i_req,
    nft_rsp_if.source   o_rsp
);

    nft_pkg::t_req req;
    nft_pkg::t_rsp rsp_new, rsp_out;
    logic          fire, buf_ready;

    assign req.op            = i_req.op;
    assign req.obj_index     = i_req.obj_index;
    assign req.signal_bits   = i_req.signal_bits;
    assign req.match_mask    = i_req.match_mask;
    assign req.caller_thread = i_req.caller_thread;

    assign i_req.ready = buf_ready;
    assign fire        = i_req.valid && buf_ready;

    nft_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (req),
        .o_rsp   (rsp_new)
    );

    nft_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (rsp_new),
        .o_ready (buf_ready),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_data  (rsp_out)
    );

    assign o_rsp.status      = rsp_out.status;
    assign o_rsp.new_index   = rsp_out.new_index;
    assign o_rsp.bits_out    = rsp_out.bits_out;
    assign o_rsp.wake        = rsp_out.wake;
    assign o_rsp.wake_thread = rsp_out.wake_thread;

endmodule

`default_nettype wire

>>> design/nft_checker.sv
// Port-level checks on the notification flag table response channel, and
// the bind that attaches them. Uses nft_pkg and the macro header.
`default_nettype none
`include "notification_flag_table_defines.svh"

module nft_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  i_status,
    input wire logic [3:0]  i_new_index,
    input wire logic [31:0] i_bits_out,
    input wire logic        i_wake,
    input wire logic [7:0]  i_wake_thread
);

    `NFT_ASSERT_NOW(a_wake_ok, i_valid && i_wake, i_status == nft_pkg::ST_OK, "wake with bad status")
    `NFT_ASSERT_NOW(a_blocked_quiet, i_valid && i_status == nft_pkg::ST_BLOCKED, !i_wake && i_bits_out == '0 && i_new_index == '0, "blocked response carries data")
    `NFT_ASSERT_NOW(a_nospace_idx, i_valid && i_status != nft_pkg::ST_OK, i_new_index == '0 && i_wake_thread == '0, "failed response carries index")
    `NFT_ASSERT_NEXT(a_hold, i_valid && !i_ready, i_valid && $stable(i_status) && $stable(i_bits_out) && $stable(i_new_index), "stalled response changed")

endmodule

bind notification_flag_table nft_checker u_nft_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_rsp.valid),
    .i_ready       (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_new_index   (o_rsp.new_index),
    .i_bits_out    (o_rsp.bits_out),
    .i_wake        (o_rsp.wake),
    .i_wake_thread (o_rsp.wake_thread)
);

`default_nettype wire
